// ----- src/tgapd_pkg.sv -----
package tgapd_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned PCNT_W  = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 2;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_BYTES_PER_PIXEL = 2'd0,
        REG_RLE_ENABLE      = 2'd1,
        REG_PIXEL_COUNT     = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    // reset values of the registers
    localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd4;
    localparam logic              RLE_RESET  = 1'b0;
    localparam logic [PCNT_W-1:0] PCNT_RESET = 32'd1;

    // three-byte pixel code and opaque alpha
    localparam logic [BPP_W-1:0]  BPP_BGR      = 3'd3;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // configuration as seen by the decoder
    typedef struct packed {
        logic [BPP_W-1:0]  bytes_per_pixel;
        logic              rle_enable;
        logic [PCNT_W-1:0] pixel_count;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [COUNT_W-1:0] repeat_count;
        logic               last_pixel;
    } result_t;

endpackage

// ----- src/tgapd_cfg_regs.sv -----
module tgapd_cfg_regs
    import tgapd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg,
    output cfg_t             cfg_new,
    output logic             restart
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic hit;

    // decode the write, the unused index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BYTES_PER_PIXEL:
                begin
                    cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                    hit = 1'b1;
                end
                REG_RLE_ENABLE:
                begin
                    cfg_next.rle_enable = cfg_data[0];
                    hit = 1'b1;
                end
                REG_PIXEL_COUNT:
                begin
                    cfg_next.pixel_count = cfg_data[PCNT_W-1:0];
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= BPP_RESET;
            cfg_reg.rle_enable      <= RLE_RESET;
            cfg_reg.pixel_count     <= PCNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg     = cfg_reg;
    assign cfg_new = cfg_next;
    assign restart = hit;

endmodule

// ----- src/tgapd_in_stage.sv -----
module tgapd_in_stage
    import tgapd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              step,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] byte_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // hold off the sender only while a byte waits and cannot move on
    assign in_stall = valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// ----- src/tgapd_decode.sv -----
module tgapd_decode
    import tgapd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  cfg_t              cfg_new,
    input  logic              restart,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_data,
    output logic              emit,
    output result_t           result
);

    logic                    awaiting_reg, awaiting_next;
    logic [1:0]              pos_reg, pos_next;
    logic [23:0]             partial_reg, partial_next;
    logic [COUNT_W-1:0]      packet_rem_reg, packet_rem_next;
    logic                    run_reg, run_next;
    logic [PCNT_W-1:0]       remaining_reg, remaining_next;

    logic                    is_bgr;
    logic                    last_byte;
    logic                    done;
    logic [COLOR_W-1:0]      color;
    logic [COUNT_W-1:0]      count_raw;
    logic [COUNT_W-1:0]      count;
    logic [COUNT_W-1:0]      rem_dec;
    logic [PCNT_W-1:0]       remaining_after;

    assign is_bgr    = (cfg.bytes_per_pixel == BPP_BGR);
    assign last_byte = is_bgr ? (pos_reg == 2'd2) : (pos_reg == 2'd3);
    assign done      = (remaining_reg == '0);

    // final color: red closes a BGR pixel, alpha closes a BGRA pixel
    assign color = is_bgr ? {ALPHA_OPAQUE, partial_reg[23:8], byte_data}
                          : {byte_data, partial_reg};

    // pixels in this result before clipping
    assign rem_dec = (packet_rem_reg != '0) ? packet_rem_reg - 8'd1 : packet_rem_reg;
    always_comb
    begin
        count_raw = 8'd1;
        if (cfg.rle_enable && run_reg && (packet_rem_reg != '0))
        begin
            count_raw = packet_rem_reg;
        end
    end

    // clip against the pixels still owed to the image
    assign count = (remaining_reg < {24'd0, count_raw}) ? remaining_reg[COUNT_W-1:0]
                                                        : count_raw;
    assign remaining_after = remaining_reg - {24'd0, count};

    // next state
    always_comb
    begin
        awaiting_next   = awaiting_reg;
        pos_next        = pos_reg;
        partial_next    = partial_reg;
        packet_rem_next = packet_rem_reg;
        run_next        = run_reg;
        remaining_next  = remaining_reg;
        emit            = 1'b0;
        if (restart)
        begin
            awaiting_next   = cfg_new.rle_enable;
            pos_next        = 2'd0;
            partial_next    = '0;
            packet_rem_next = '0;
            run_next        = 1'b0;
            remaining_next  = cfg_new.pixel_count;
        end
        else if (step && !done)
        begin
            if (cfg.rle_enable && awaiting_reg)
            begin
                // packet header
                run_next        = byte_data[7];
                packet_rem_next = {1'b0, byte_data[6:0]} + 8'd1;
                awaiting_next   = 1'b0;
                pos_next        = 2'd0;
                partial_next    = '0;
            end
            else if (!last_byte)
            begin
                // blue, green, then red of a four-byte pixel
                unique case (pos_reg)
                    2'd0:    partial_next[23:16] = byte_data;
                    2'd1:    partial_next[15:8]  = byte_data;
                    default: partial_next[7:0]   = byte_data;
                endcase
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                // pixel complete
                emit           = 1'b1;
                pos_next       = 2'd0;
                partial_next   = '0;
                remaining_next = remaining_after;
                if (cfg.rle_enable)
                begin
                    if (run_reg)
                    begin
                        packet_rem_next = '0;
                        awaiting_next   = 1'b1;
                    end
                    else
                    begin
                        packet_rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            awaiting_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= RLE_RESET;
            pos_reg        <= 2'd0;
            partial_reg    <= '0;
            packet_rem_reg <= '0;
            run_reg        <= 1'b0;
            remaining_reg  <= PCNT_RESET;
        end
        else
        begin
            awaiting_reg   <= awaiting_next;
            pos_reg        <= pos_next;
            partial_reg    <= partial_next;
            packet_rem_reg <= packet_rem_next;
            run_reg        <= run_next;
            remaining_reg  <= remaining_next;
        end
    end

    assign result.pixel_color  = color;
    assign result.repeat_count = count;
    assign result.last_pixel   = (remaining_after == '0);

endmodule

// ----- src/tgapd_out_stage.sv -----
module tgapd_out_stage
    import tgapd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               emit,
    input  result_t            result,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COLOR_W-1:0] pixel_color,
    output logic [COUNT_W-1:0] repeat_count,
    output logic               last_pixel
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    load;

    // register can take a new item when empty or being drained
    assign ready = !valid_reg || !out_stall;
    assign load  = step && emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_color  = result_reg.pixel_color;
    assign repeat_count = result_reg.repeat_count;
    assign last_pixel   = result_reg.last_pixel;

endmodule

// ----- src/tga_truecolor_pixel_decoder_top.sv -----
// True-color TGA pixel-data decoder.
// Input channel: in_valid / in_stall carry one pixel-data byte per item
// (data_byte). Output channel: out_valid / out_stall carry one run item:
// pixel_color (red in bits 7:0, alpha in 31:24), repeat_count (1 to 128)
// and last_pixel, set on the item that completes the image.
// Header bytes and partial pixels give no output item; bytes after the
// last pixel are dropped.
// Throughput: one byte per clock while the receiver does not stall, set by
// the single decode stage between the input byte register and the output
// result register. A pixel's last byte is decoded from the input register
// and its item is loaded into the result register, which raises out_valid.
// When the receiver stalls, the result register holds its item and the
// waiting byte stays in the input register; in_stall rises only while both
// are full. Reset empties both registers and loads bytes_per_pixel = 4,
// rle_enable = 0, pixel_count = 1. A write to index 0, 1 or 2 through
// cfg_write / cfg_index / cfg_data restarts the image; write only when idle.
module tga_truecolor_pixel_decoder_top
    import tgapd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COLOR_W-1:0] pixel_color,
    output logic [COUNT_W-1:0] repeat_count,
    output logic               last_pixel
);

    cfg_t              cfg;
    cfg_t              cfg_new;
    logic              restart;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              ready;
    logic              step;
    logic              emit;
    result_t           result;

    // a waiting byte is decoded when the result register can take it
    assign step = byte_valid && ready;

    tgapd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_new   (cfg_new),
        .restart   (restart)
    );

    tgapd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .step       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    tgapd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_new   (cfg_new),
        .restart   (restart),
        .step      (step),
        .byte_data (byte_data),
        .emit      (emit),
        .result    (result)
    );

    tgapd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .emit         (emit),
        .result       (result),
        .ready        (ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_color  (pixel_color),
        .repeat_count (repeat_count),
        .last_pixel   (last_pixel)
    );

endmodule

// ----- sim/tb_tga_truecolor_pixel_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_tga_truecolor_pixel_decoder_top;
    import tgapd_pkg::*;

    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned ITEM_GOAL   = 1550;
    localparam int unsigned MAX_PRINTS  = 40;

    localparam logic [PCNT_W-1:0] PCNT_MAX       = 32'hFFFF_FFFF;
    localparam logic [PCNT_W-1:0] PCNT_IMAGE_MAX = 32'hFFFE_0001;
    localparam logic [BYTE_W-1:0] RUN_FLAG       = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_MASK       = 8'h7F;

    // tracks decoder state and holds the runs still to come out
    class pixel_run_tracker;
        logic [BPP_W-1:0]  bytes_per_pixel;
        logic              rle_enable;
        logic [PCNT_W-1:0] pixel_count;
        logic              header_next;
        logic [1:0]        byte_pos;
        logic [23:0]       partial;
        logic [7:0]        packet_left;
        logic              in_run;
        logic [PCNT_W-1:0] emitted;
        logic              complete;
        result_t           expected_runs[$];
        int                errors;

        function new();
            bytes_per_pixel = BPP_RESET;
            rle_enable      = RLE_RESET;
            pixel_count     = PCNT_RESET;
            errors          = 0;
            restart();
        endfunction

        // start of a new image
        function void restart();
            header_next = rle_enable;
            byte_pos    = '0;
            partial     = '0;
            packet_left = '0;
            in_run      = 1'b0;
            emitted     = '0;
            complete    = 1'b0;
        endfunction

        // register write, unused index changes nothing
        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_BYTES_PER_PIXEL: bytes_per_pixel = value[BPP_W-1:0];
                REG_RLE_ENABLE:      rle_enable = value[0];
                REG_PIXEL_COUNT:     pixel_count = value;
                default:             return;
            endcase
            restart();
        endfunction

        function bit image_over();
            return complete || (emitted >= pixel_count);
        endfunction

        function int pixel_bytes();
            return (bytes_per_pixel == BPP_BGR) ? 3 : 4;
        endfunction

        // decode one accepted byte, returns 0 when the byte is dropped
        function bit take_byte(logic [BYTE_W-1:0] b);
            logic [1:0]         last_pos;
            logic [COLOR_W-1:0] color;
            logic [PCNT_W-1:0]  count;
            logic [PCNT_W-1:0]  remain;
            result_t            run;
            last_pos = (bytes_per_pixel == BPP_BGR) ? 2'd2 : 2'd3;
            if (image_over())
                return 0;

            // packet header
            if (rle_enable && header_next)
            begin
                in_run      = b[7];
                packet_left = (b & LEN_MASK) + 8'd1;
                header_next = 1'b0;
                byte_pos    = '0;
                partial     = '0;
                return 1;
            end

            // blue, green, then red for four-byte pixels
            if (byte_pos < last_pos)
            begin
                case (byte_pos)
                    2'd0:    partial[23:16] = b;
                    2'd1:    partial[15:8]  = b;
                    default: partial[7:0]   = b;
                endcase
                byte_pos++;
                return 1;
            end

            // final byte: red for BGR, alpha for BGRA
            if (last_pos == 2'd2)
                color = {ALPHA_OPAQUE, partial[23:8], b};
            else
                color = {b, partial};
            byte_pos = '0;
            partial  = '0;

            count = 32'd1;
            if (rle_enable && in_run)
            begin
                count       = {24'd0, packet_left};
                packet_left = '0;
                header_next = 1'b1;
            end
            else if (rle_enable)
            begin
                if (packet_left != 0)
                    packet_left--;
                if (packet_left == 0)
                    header_next = 1'b1;
            end
            if (count == 0)
                count = 32'd1;

            // clip to the pixels left in the image
            remain = pixel_count - emitted;
            if (count > remain)
                count = remain;
            emitted += count;
            if (emitted == pixel_count)
                complete = 1'b1;

            run.pixel_color  = color;
            run.repeat_count = count[COUNT_W-1:0];
            run.last_pixel   = complete;
            expected_runs.push_back(run);
            return 1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        // compare one output run with the oldest expected run
        task check_run(logic [COLOR_W-1:0] color, logic [COUNT_W-1:0] count, logic last);
            result_t want;
            if (expected_runs.size() == 0)
            begin
                report($sformatf("unexpected run color %h count %0d last %b",
                                 color, count, last));
                return;
            end
            want = expected_runs.pop_front();
            if (color !== want.pixel_color)
                report($sformatf("pixel_color %h, expected %h", color, want.pixel_color));
            if (count !== want.repeat_count)
                report($sformatf("repeat_count %0d, expected %0d", count, want.repeat_count));
            if (last !== want.last_pixel)
                report($sformatf("last_pixel %b, expected %b", last, want.last_pixel));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  data_byte;
    logic               out_valid;
    logic               out_stall;
    logic [COLOR_W-1:0] pixel_color;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_pixel;

    pixel_run_tracker decoder_model;
    int               tx_idle_pct;
    int               rx_stall_pct;
    int               used_items;
    bit               hold_req;

    tga_truecolor_pixel_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_color  (pixel_color),
        .repeat_count (repeat_count),
        .last_pixel   (last_pixel)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #3_000_000;
        $display("tb_tga_truecolor_pixel_decoder_top: FAIL");
        $finish;
    end

    // offer one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (decoder_model.take_byte(b))
            used_items++;
    endtask

    // drop valid and wait until the decoder has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (decoder_model.expected_runs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_write high, the caller lowers it
    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        decoder_model.write_reg(idx, value);
    endtask

    // all three registers, unused data bits randomized
    task automatic configure(input logic [BPP_W-1:0] bpp, input logic rle,
                             input logic [PCNT_W-1:0] pcnt);
        logic [CFG_W-1:0] value;
        value = $urandom;
        value[BPP_W-1:0] = bpp;
        write_reg(REG_BYTES_PER_PIXEL, value);
        value = $urandom;
        value[0] = rle;
        write_reg(REG_RLE_ENABLE, value);
        write_reg(REG_PIXEL_COUNT, pcnt);
        cfg_write <= 1'b0;
    endtask

    // well-formed packets with random content, cut off at the item target
    task automatic send_stream(input int target);
        int               start;
        int               npix;
        logic [BYTE_W-1:0] hdr;
        start = used_items;
        while (used_items - start < target && !decoder_model.image_over())
        begin
            npix = 1;
            if (decoder_model.rle_enable)
            begin
                hdr = 8'($urandom_range(255));
                hdr[6:0] = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(5));
                send_byte(hdr);
                npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
            end
            for (int i = 0; i < npix * decoder_model.pixel_bytes()
                            && used_items - start < target
                            && !decoder_model.image_over(); i++)
                send_byte(8'($urandom_range(255)));
        end
        // a few trailing bytes, dropped once the image is complete
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
    endtask

    // receiver: check accepted runs and drive the stall
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                decoder_model.check_run(pixel_color, repeat_count, last_pixel);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // stimulus
    initial
    begin
        logic [BPP_W-1:0]  bpp;
        logic [PCNT_W-1:0] pcnt;
        int                pick;
        decoder_model = new();
        used_items    = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_req      = 1'b0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_BYTES_PER_PIXEL;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one BGRA pixel, then bytes after completion
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        // BGR run of 128 clipped to five pixels
        configure(BPP_BGR, 1'b1, 32'd5);
        send_byte(RUN_FLAG | LEN_MASK);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h12);
        settle();

        // bytes_per_pixel of 0 acts as BGRA, single-pixel raw packet
        configure(3'd0, 1'b1, PCNT_MAX);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        settle();

        // unused index must not restart the image, then a full run
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_write <= 1'b0;
        send_byte(RUN_FLAG | LEN_MASK);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hC3);
        send_byte(8'h3C);
        settle();

        // zero pixel count drops every byte
        configure(3'd7, 1'b0, '0);
        send_byte(8'hA5);
        send_byte(8'h5A);
        settle();

        // long receiver hold while bytes keep coming
        configure(BPP_BGR, 1'b0, PCNT_IMAGE_MAX);
        hold_req = 1'b1;
        repeat (300) send_byte(8'($urandom_range(255)));
        settle();

        // random images under rotating idle patterns
        for (int phase = 0; used_items < ITEM_GOAL; phase++)
        begin
            case (phase % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 52; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            pick = $urandom_range(9);
            if (pick < 2)
                bpp = 3'($urandom_range(7));
            else if (pick < 6)
                bpp = BPP_BGR;
            else
                bpp = BPP_RESET;
            pick = $urandom_range(19);
            if (pick == 0)
                pcnt = '0;
            else if (pick == 1)
                pcnt = PCNT_MAX;
            else if (pick == 2)
                pcnt = PCNT_IMAGE_MAX;
            else if (pick < 6)
                pcnt = $urandom_range(1, 4);
            else
                pcnt = $urandom_range(1, 80);
            configure(bpp, 1'($urandom_range(1)), pcnt);
            send_stream($urandom_range(20, 120));
            settle();
        end

        repeat (10) @(posedge clk);
        if (decoder_model.errors == 0)
            $display("tb_tga_truecolor_pixel_decoder_top: PASS");
        else
            $display("tb_tga_truecolor_pixel_decoder_top: FAIL");
        $finish;
    end

endmodule
